// File: src/cylinder_axial_histogram_top_assert.svh
// assertion macros shared by the histogram block
`ifndef CYLINDER_AXIAL_HISTOGRAM_TOP_ASSERT_SVH
`define CYLINDER_AXIAL_HISTOGRAM_TOP_ASSERT_SVH

// implication checked at every clock edge outside reset
`define CAH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define CAH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/cah_pkg.sv
// ---------------------------------------------------------------------------
// cah_pkg
// shared types and constants of the cylinder axial histogram
// ---------------------------------------------------------------------------
`default_nettype none
package cah_pkg;
  localparam int BINS = 64;
  localparam int SPECIES = 8;
  localparam int FRAC_BITS = 16;
  localparam int BIN_W = 6;
  localparam int SP_W = 3;
  localparam int ADDR_W = SP_W + BIN_W;
  localparam int DEPTH = SPECIES * BINS;

  localparam logic [1:0] MODE_ADD1 = 2'd0;
  localparam logic [1:0] MODE_ADDN = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_RDCLR = 2'd3;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_BIN_INT = 3'd6;
  localparam logic [2:0] REG_MAX_RAD = 3'd7;

  // command passed from the geometry front to the counter back end
  typedef struct packed {
    logic [1:0]        mode;
    logic              hit;
    logic [BIN_W-1:0]  bin;
    logic [SP_W-1:0]   species;
    logic [15:0]       add_count;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic [30:0]        bin_interval;
    logic [30:0]        max_radius;
  } cfg_t;
endpackage
`default_nettype wire

// File: src/cah_front.sv
// ---------------------------------------------------------------------------
// cah_front
// geometry front: projects a point onto the axis, finds its bin and the
// radial test, one item at a time through a short sequence of steps
// ---------------------------------------------------------------------------
`default_nettype none
module cah_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cah_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          mode,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic [2:0]          species,
  input  wire logic [15:0]         add_count,
  input  wire logic [5:0]          read_bin,
  output logic                     cmd_valid,
  input  wire logic                cmd_stall,
  output cah_pkg::cmd_t            cmd
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PROD = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RMUL = 8'b0001_0000,
    S_RSUB = 8'b0010_0000,
    S_SQ   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } st_t;

  st_t state;
  logic [1:0] md;
  logic [2:0] sp;
  logic [15:0] addc;
  logic [5:0] rbin;
  logic signed [32:0] ex, ey, ez;
  logic signed [50:0] px, py, pz;
  logic signed [52:0] t;
  logic [52:0] rem;
  logic [47:0] dvs;
  logic [6:0] q;
  logic [2:0] dcnt;
  logic signed [36:0] tq;
  logic signed [54:0] mx, my, mz;
  logic signed [40:0] rx, ry, rz;
  logic [40:0] ax, ay, az;
  logic [81:0] sx, sy, sz;
  logic [83:0] r2sum;
  logic bad;

  // restoring division by bin_interval<<FRAC_BITS, quotient of 6 bits held in q:
  // bin >= 64 when t >= 64*divisor, checked first
  logic [53:0] dsh;
  logic [47:0] bi;
  assign bi = {1'b0, (cfg.bin_interval == 31'd0) ? 31'd1 : cfg.bin_interval,
               {cah_pkg::FRAC_BITS{1'b0}}};
  assign dsh = {6'd0, dvs} << dcnt;

  assign in_stall = (state != S_IDLE);
  assign cmd_valid = (state == S_OUT);

  function automatic logic [40:0] absv(input logic signed [40:0] v);
    absv = v[40] ? 41'(-v) : 41'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            md <= mode;
            sp <= species;
            addc <= add_count;
            rbin <= read_bin;
            ex <= 33'(pos_x) - 33'(cfg.start_x);
            ey <= 33'(pos_y) - 33'(cfg.start_y);
            ez <= 33'(pos_z) - 33'(cfg.start_z);
            state <= (mode[1]) ? S_OUT : S_PROD;
          end
        end
        S_PROD: begin
          px <= 51'(cfg.dir_x) * 51'(ex);
          py <= 51'(cfg.dir_y) * 51'(ey);
          pz <= 51'(cfg.dir_z) * 51'(ez);
          state <= S_SUM;
        end
        S_SUM: begin
          t <= 53'(px) + 53'(py) + 53'(pz);
          dvs <= bi;
          dcnt <= 3'd6;
          q <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == 3'd6) begin
            rem <= t;
            bad <= t[52] || ({1'b0, t} >= dsh);
            tq <= 37'(t >>> cah_pkg::FRAC_BITS);
          end else if (({1'b0, rem}) >= {1'b0, dsh[52:0]} && !dsh[53]) begin
            rem <= rem - dsh[52:0];
            q[dcnt] <= 1'b1;
          end
          if (dcnt == 3'd6 && (t[52] || ({1'b0, t} >= dsh))) begin
            state <= S_OUT;
          end else if (dcnt == 3'd0 && dcnt != 3'd6) begin
            state <= S_RMUL;
          end
          dcnt <= (dcnt == 3'd6) ? 3'd5 : dcnt - 3'd1;
        end
        S_RMUL: begin
          mx <= 55'(cfg.dir_x) * 55'(tq);
          my <= 55'(cfg.dir_y) * 55'(tq);
          mz <= 55'(cfg.dir_z) * 55'(tq);
          state <= S_RSUB;
        end
        S_RSUB: begin
          rx <= 41'(ex) - 41'(mx >>> cah_pkg::FRAC_BITS);
          ry <= 41'(ey) - 41'(my >>> cah_pkg::FRAC_BITS);
          rz <= 41'(ez) - 41'(mz >>> cah_pkg::FRAC_BITS);
          state <= S_SQ;
        end
        S_SQ: begin
          ax <= absv(rx);
          ay <= absv(ry);
          az <= absv(rz);
          bad <= (absv(rx) > 41'(cfg.max_radius)) || (absv(ry) > 41'(cfg.max_radius))
              || (absv(rz) > 41'(cfg.max_radius));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!cmd_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // radial squares use the low 31 bits; they count only when the per-axis bound holds (< 2^31)
  always_comb begin
    sx = 82'(ax[30:0]) * 82'(ax[30:0]);
    sy = 82'(ay[30:0]) * 82'(ay[30:0]);
    sz = 82'(az[30:0]) * 82'(az[30:0]);
    r2sum = 84'(sx) + 84'(sy) + 84'(sz);
    cmd.mode = md;
    cmd.species = sp;
    cmd.add_count = addc;
    if (md[1]) begin
      cmd.hit = 1'b0;
      cmd.bin = rbin;
    end else begin
      cmd.hit = !bad && (r2sum <= 84'(62'(cfg.max_radius) * 62'(cfg.max_radius)));
      cmd.bin = q[5:0];
    end
  end
endmodule
`default_nettype wire

// File: src/cah_queue.sv
// ---------------------------------------------------------------------------
// cah_queue
// two-entry queue between geometry front and counter back end
// ---------------------------------------------------------------------------
`default_nettype none
module cah_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_stall,
  input  wire cah_pkg::cmd_t  wr_data,
  output logic                rd_valid,
  input  wire logic           rd_stall,
  output cah_pkg::cmd_t       rd_data
);
  cah_pkg::cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: src/cah_back.sv
// ---------------------------------------------------------------------------
// cah_back
// counter back end: read-modify-write of the histogram memory, clearing
// pass after reset, registered result
// ---------------------------------------------------------------------------
`default_nettype none
`include "cylinder_axial_histogram_top_assert.svh"
module cah_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire cah_pkg::cmd_t  cmd,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                inside_res,
  output logic [5:0]          bin_index,
  output logic [31:0]         count
);
  typedef enum logic [2:0] {
    B_CLR  = 3'b001,
    B_IDLE = 3'b010,
    B_UPD  = 3'b100
  } bst_t;

  bst_t state;
  logic [31:0] mem [cah_pkg::DEPTH];
  logic [31:0] rdata;
  logic [cah_pkg::ADDR_W:0] clr_cnt;
  logic [cah_pkg::ADDR_W-1:0] addr;
  cah_pkg::cmd_t cur;
  logic inrange;
  logic take;
  logic [32:0] sum;
  logic [31:0] wval;
  logic wen;
  logic [cah_pkg::ADDR_W-1:0] waddr;

  // species and bin widths cover their ranges exactly, so every item is in range
  assign inrange = 1'b1;
  assign take = (state == B_IDLE) && cmd_valid && (!out_valid || !out_stall);
  assign cmd_stall = !take;
  assign addr = {cmd.species, cmd.bin};

  assign sum = {1'b0, rdata} + ((cur.mode == cah_pkg::MODE_ADDN) ?
                                33'(cur.add_count) : 33'd1);

  always_comb begin
    wen = 1'b0;
    waddr = {cur.species, cur.bin};
    wval = '0;
    if (state == B_CLR) begin
      wen = 1'b1;
      waddr = clr_cnt[cah_pkg::ADDR_W-1:0];
    end else if (state == B_UPD) begin
      if (cur.mode == cah_pkg::MODE_RDCLR) begin
        wen = 1'b1;
      end else if (!cur.mode[1] && cur.hit) begin
        wen = 1'b1;
        wval = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wval;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        B_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (cah_pkg::ADDR_W+1)'(cah_pkg::DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (take) begin
            cur <= cmd;
            state <= B_UPD;
          end
        end
        B_UPD: begin
          out_valid <= 1'b1;
          inside_res <= !cur.mode[1] && cur.hit;
          bin_index <= (cur.mode[1] || cur.hit) ? cur.bin : 6'd0;
          count <= (cur.mode[1] && inrange) ? rdata : 32'd0;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `CAH_ASSERT_IMP(a_no_take_in_clear, state == B_CLR, cmd_stall)
  `CAH_ASSERT_NEXT(a_take_upd, take, state == B_UPD)
  `CAH_ASSERT_NEXT(a_upd_out, state == B_UPD, out_valid)
endmodule
`default_nettype wire

// File: src/cylinder_axial_histogram_top.sv
// ---------------------------------------------------------------------------
// cylinder_axial_histogram_top
// axial histogram of particle positions along a cylinder axis
// ---------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  mode pos_x pos_y pos_z species add_count read_bin
// out      output     out_valid/out_stall inside_res bin_index count
// cfg      input      apb                8 registers, 32-bit data
//
// a point passes through the geometry front in order: capture, projection multiply,
// sum, 7 bin divider steps, residual multiply, subtract, radial bound, hand-off;
// a point behind the start or past the last bin leaves after the first divider step;
// reads go from capture straight to hand-off. the counter back end reads the memory,
// then writes it, taking no new item meanwhile. after reset it clears the 512 counters,
// one per cycle, while the geometry front already accepts items; a stalled output holds.
`default_nettype none
module cylinder_axial_histogram_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [2:0]         species,
  input  wire logic [15:0]        add_count,
  input  wire logic [5:0]         read_bin,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    inside_res,
  output logic [5:0]              bin_index,
  output logic [31:0]             count
);
  cah_pkg::cfg_t cfg;
  cah_pkg::cmd_t f_cmd, b_cmd;
  logic f_valid, f_stall, b_valid, b_stall;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x <= '0;
      cfg.start_y <= '0;
      cfg.start_z <= '0;
      cfg.dir_x <= 18'sd65536;
      cfg.dir_y <= '0;
      cfg.dir_z <= '0;
      cfg.bin_interval <= 31'd65536;
      cfg.max_radius <= 31'd65536;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (ridx)
        cah_pkg::REG_START_X: cfg.start_x <= pwdata;
        cah_pkg::REG_START_Y: cfg.start_y <= pwdata;
        cah_pkg::REG_START_Z: cfg.start_z <= pwdata;
        cah_pkg::REG_DIR_X:   cfg.dir_x <= pwdata[17:0];
        cah_pkg::REG_DIR_Y:   cfg.dir_y <= pwdata[17:0];
        cah_pkg::REG_DIR_Z:   cfg.dir_z <= pwdata[17:0];
        cah_pkg::REG_BIN_INT: cfg.bin_interval <= pwdata[30:0];
        cah_pkg::REG_MAX_RAD: cfg.max_radius <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      cah_pkg::REG_START_X: prdata = cfg.start_x;
      cah_pkg::REG_START_Y: prdata = cfg.start_y;
      cah_pkg::REG_START_Z: prdata = cfg.start_z;
      cah_pkg::REG_DIR_X:   prdata = 32'(cfg.dir_x);
      cah_pkg::REG_DIR_Y:   prdata = 32'(cfg.dir_y);
      cah_pkg::REG_DIR_Z:   prdata = 32'(cfg.dir_z);
      cah_pkg::REG_BIN_INT: prdata = {1'b0, cfg.bin_interval};
      cah_pkg::REG_MAX_RAD: prdata = {1'b0, cfg.max_radius};
      default:              prdata = '0;
    endcase
  end

  cah_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_stall, .mode, .pos_x, .pos_y, .pos_z,
    .species, .add_count, .read_bin,
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  cah_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_cmd)
  );

  cah_back u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd(b_cmd),
    .out_valid, .out_stall, .inside_res, .bin_index, .count
  );
endmodule
`default_nettype wire
